### rtl/gbkf_pkg.sv
// Shared types, constants and a saturation helper for the gyro bias Kalman filter.
package gbkf_pkg;

  localparam int NumRegs = 7;
  localparam int AddrW   = 5;

  // register byte addresses (index times four)
  localparam logic [AddrW-1:0] ADDR_P_AA = 5'd0;
  localparam logic [AddrW-1:0] ADDR_P_AB = 5'd4;
  localparam logic [AddrW-1:0] ADDR_P_BA = 5'd8;
  localparam logic [AddrW-1:0] ADDR_P_BB = 5'd12;
  localparam logic [AddrW-1:0] ADDR_Q_H  = 5'd16;
  localparam logic [AddrW-1:0] ADDR_Q_B  = 5'd20;
  localparam logic [AddrW-1:0] ADDR_R    = 5'd24;

  localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

  // command codes
  localparam logic [1:0] CMD_RATE  = 2'd0;
  localparam logic [1:0] CMD_YAW   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_START, OP_R_HEAD, OP_R_A, OP_R_P11, OP_R_P01A, OP_R_P01B,
    OP_Y_PREP, OP_Y_DIV0, OP_Y_K0, OP_Y_DIV1, OP_Y_K1, OP_Y_HEAD,
    OP_Y_DIV2, OP_Y_BIAS, OP_ECHO
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] cmd;
    logic       first;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic skip_gain;
    logic t_zero;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### rtl/gbkf_div.sv
// Radix-2 restoring divider for magnitudes, one quotient bit a cycle.
module gbkf_div import gbkf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [63:0] quo
);
  logic [63:0] rem;
  logic [6:0]  cnt;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, den};

  // shift the dividend out at the top and the quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
      rem  <= '0;
      quo  <= num;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule

### rtl/gbkf_dp.sv
// Datapath: filter state, one multiplier, shared divider, result register.
module gbkf_dp import gbkf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            c,
  input  logic signed [31:0] sample,
  input  logic [23:0]        tstep,
  input  logic signed [31:0] r_p [4],
  input  logic signed [31:0] q_heading,
  input  logic signed [31:0] q_bias,
  input  logic signed [31:0] r_meas,
  output dp_stat_t           st,
  output logic [1:0]         o_kind,
  output logic signed [31:0] o_frate,
  output logic signed [31:0] o_head,
  output logic               o_ok
);
  logic signed [31:0] heading, bias, p00, p01, p10, p11;
  logic signed [31:0] acc, k0, k1, innov, tmp, smp;
  logic signed [33:0] s;
  logic [24:0]        t, t_mul;
  logic               neg;
  logic               div_start, div_busy;
  logic [63:0]        div_num, div_den, div_q;
  logic signed [63:0] mul_a;
  logic signed [63:0] prod;
  logic signed [71:0] rnd20, rnd24;
  logic signed [64:0] qs;

  // single shared multiplier: operand by dt or by innovation
  always_comb begin
    unique case (c.op)
      OP_R_HEAD:  mul_a = 64'(sample) - 64'(bias);
      OP_R_A:     mul_a = 64'(p10);
      OP_R_P11:   mul_a = 64'(p11);
      OP_R_P01A:  mul_a = 64'(acc);
      OP_Y_HEAD:  mul_a = 64'(k0);
      OP_Y_DIV2:  mul_a = 64'(k1);
      default:    mul_a = '0;
    endcase
  end
  // dt of the word being accepted is not registered yet
  assign t_mul = (c.op == OP_R_HEAD) ? (c.first ? 25'd0 : {1'b0, tstep}) : t;
  assign prod  = (c.op == OP_Y_HEAD || c.op == OP_Y_DIV2) ? mul_a * 64'(innov)
                                                          : mul_a * $signed({39'd0, t_mul});
  assign rnd20 = (72'(prod) + 72'sd524288) >>> 20;
  assign rnd24 = (72'(prod) + 72'sd8388608) >>> 24;
  assign qs    = neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  assign st.div_busy  = div_start | div_busy;
  assign st.skip_gain = (s <= 0);
  assign st.t_zero    = (t == '0);

  gbkf_div u_div (.clk, .rst, .start(div_start), .num(div_num), .den(div_den),
                  .busy(div_busy), .quo(div_q));

  // state and result updates per operation
  always_ff @(posedge clk) begin
    if (rst) begin
      heading <= '0; bias <= '0;
      p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (c.op)
        OP_START: begin
          p00 <= r_p[0]; p01 <= r_p[1]; p10 <= r_p[2]; p11 <= r_p[3];
        end
        OP_R_HEAD: begin
          t       <= c.first ? 25'd0 : {1'b0, tstep};
          o_frate <= sat32(72'(sample) - 72'(bias));
          heading <= sat32(72'(heading) + rnd20);
        end
        OP_R_A: begin
          tmp <= sat32(rnd20);
          acc <= sat32(72'(p00) - 72'(sat32(rnd20)));
        end
        OP_R_P11: begin
          p00 <= sat32(72'(acc) + 72'(q_heading));
          p11 <= sat32(72'(tmp) + 72'(p11) + 72'(q_bias));
          tmp <= sat32(rnd20);
        end
        OP_R_P01A: begin
          p01 <= sat32(72'(sat32(rnd20)) + 72'(p01) - 72'(tmp));
        end
        OP_Y_PREP: begin
          t <= c.first ? 25'd0 : {1'b0, tstep};
          smp <= sample;
          if (c.first) heading <= sample;
          s <= 34'(p00) + 34'(r_meas);
          k0 <= '0; k1 <= '0;
        end
        OP_Y_DIV0: begin
          neg <= p00[31];
          div_den <= 64'(s);
          div_start <= 1'b1;
          div_num <= ((p00[31] ? 64'(-64'(p00)) : 64'(p00)) << 24) + 64'(s >>> 1);
        end
        OP_Y_K0: k0 <= sat32(72'(qs));
        OP_Y_DIV1: begin
          neg <= p10[31];
          div_den <= 64'(s);
          div_num <= ((p10[31] ? 64'(-64'(p10)) : 64'(p10)) << 24) + 64'(s >>> 1);
          div_start <= 1'b1;
        end
        OP_Y_K1: begin
          k1 <= st.skip_gain ? 32'sd0 : sat32(72'(qs));
          innov <= sat32(72'(smp) - 72'(heading));
        end
        OP_Y_HEAD: heading <= sat32(72'(heading) + rnd24);
        OP_Y_DIV2: begin
          neg <= prod[63];
          div_den <= 64'(t) << 4;
          div_num <= (prod[63] ? 64'(-prod) : 64'(prod)) + (64'(t) << 3);
          div_start <= 1'b1;
        end
        OP_Y_BIAS: bias <= sat32(72'(bias) + 72'(sat32(72'(qs))));
        OP_ECHO: begin
          o_kind <= c.cmd;
          o_head <= heading;
          o_ok   <= (c.cmd == CMD_START) && c.first;
          if (c.cmd != CMD_RATE) o_frate <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/gbkf_ctrl.sv
// Controller: sequences datapath operations and the stream handshake.
module gbkf_ctrl import gbkf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  dp_stat_t   st,
  output dp_cmd_t    c,
  output logic       out_valid,
  input  logic       out_ready
);
  typedef enum logic [3:0] {
    S_IDLE, S_R1, S_R2, S_R3, S_Y1, S_Y2, S_Y3, S_Y4, S_Y5, S_Y6, S_Y7, S_Y8,
    S_ECHO, S_OUT
  } state_t;

  state_t     state;
  logic       running, rate_seen, yaw_seen, first;
  logic [1:0] cmd;

  assign in_ready = (state == S_IDLE) && !out_valid;

  // operation issued in each state; divider waits end in the K0, K1 and bias steps
  always_comb begin
    c.cmd = cmd;
    c.first = first;
    unique case (state)
      S_R1: c.op = OP_R_A;
      S_R2: c.op = OP_R_P11;
      S_R3: c.op = OP_R_P01A;
      S_Y1: c.op = st.skip_gain ? OP_NONE : OP_Y_DIV0;
      S_Y2: c.op = st.div_busy ? OP_NONE : OP_Y_K0;
      S_Y3: c.op = st.skip_gain ? OP_NONE : OP_Y_DIV1;
      S_Y4: c.op = st.div_busy ? OP_NONE : OP_Y_K1;
      S_Y5: c.op = OP_Y_K1;
      S_Y6: c.op = OP_Y_HEAD;
      S_Y7: c.op = st.t_zero ? OP_NONE : OP_Y_DIV2;
      S_Y8: c.op = st.div_busy ? OP_NONE : OP_Y_BIAS;
      S_ECHO: c.op = OP_ECHO;
      S_IDLE: begin
        if (in_valid && in_ready && in_cmd == CMD_RATE && running) c.op = OP_R_HEAD;
        else if (in_valid && in_ready && in_cmd == CMD_YAW && running) c.op = OP_Y_PREP;
        else if (in_valid && in_ready && in_cmd == CMD_START && !running) c.op = OP_START;
        else c.op = OP_NONE;
        c.cmd = in_cmd;
        c.first = (in_cmd == CMD_RATE) ? !rate_seen : !yaw_seen;
      end
      default: c.op = OP_NONE;
    endcase
  end

  // state and the registered output valid of the handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      running <= 1'b0; rate_seen <= 1'b0; yaw_seen <= 1'b0;
      first <= 1'b0; cmd <= CMD_RATE;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          cmd <= in_cmd;
          unique case (in_cmd)
            CMD_START: begin first <= !running; running <= 1'b1; state <= S_ECHO; end
            CMD_RATE: if (running) begin
              first <= !rate_seen; rate_seen <= 1'b1; state <= S_R1;
            end
            CMD_YAW: if (running) begin
              first <= !yaw_seen; yaw_seen <= 1'b1; state <= S_Y1;
            end
            default: ;
          endcase
        end
        S_R1: state <= S_R2;
        S_R2: state <= S_R3;
        S_R3: state <= S_ECHO;
        S_Y1: state <= st.skip_gain ? S_Y5 : S_Y2;
        S_Y2: if (!st.div_busy) state <= S_Y3;
        S_Y3: state <= S_Y4;
        S_Y4: if (!st.div_busy) state <= S_Y5;
        S_Y5: state <= S_Y6;
        S_Y6: state <= S_Y7;
        S_Y7: state <= st.t_zero ? S_ECHO : S_Y8;
        S_Y8: if (!st.div_busy) state <= S_ECHO;
        S_ECHO: state <= S_OUT;
        S_OUT: begin out_valid <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state != S_OUT) else $error("result while finishing");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_run: assert property (@(posedge clk) disable iff (rst)
    $fell(running) |-> 1'b0) else $error("running dropped");
endmodule

### rtl/gyro_bias_kalman_filter.sv
// Two-state heading and gyro bias Kalman filter with an APB register port.
// Takes one word at a time. A yaw word makes up to three passes of the shared 64-bit
// one-bit-per-cycle divider (gains and bias step).
// A result waits in the output register until taken.
module gyro_bias_kalman_filter import gbkf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // sample_value[31:0], time_step[55:32]
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // filtered_rate[31:0], heading_estimate[63:32],
                                 // start_ok[64], zeros
  output logic [1:0]  m_tuser,   // kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic signed [31:0] regs [NumRegs];
  logic signed [31:0] p_init [4];
  dp_cmd_t  c;
  dp_stat_t st;
  logic signed [31:0] fr, hd;
  logic ok;

  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= ONE_Q24; regs[1] <= '0; regs[2] <= '0; regs[3] <= ONE_Q24;
      regs[4] <= '0; regs[5] <= '0; regs[6] <= ONE_Q24;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        ADDR_P_AA: regs[0] <= pwdata;
        ADDR_P_AB: regs[1] <= pwdata;
        ADDR_P_BA: regs[2] <= pwdata;
        ADDR_P_BB: regs[3] <= pwdata;
        ADDR_Q_H:  regs[4] <= pwdata;
        ADDR_Q_B:  regs[5] <= pwdata;
        ADDR_R:    regs[6] <= pwdata;
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr)
      ADDR_P_AA: prdata = regs[0];
      ADDR_P_AB: prdata = regs[1];
      ADDR_P_BA: prdata = regs[2];
      ADDR_P_BB: prdata = regs[3];
      ADDR_Q_H:  prdata = regs[4];
      ADDR_Q_B:  prdata = regs[5];
      ADDR_R:    prdata = regs[6];
      default:   prdata = '0;
    endcase
  end

  assign p_init[0] = regs[0];
  assign p_init[1] = regs[1];
  assign p_init[2] = regs[2];
  assign p_init[3] = regs[3];

  gbkf_ctrl u_ctrl (.clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
                    .in_cmd(s_tuser), .st, .c, .out_valid(m_tvalid), .out_ready(m_tready));

  gbkf_dp u_dp (.clk, .rst, .c, .sample(s_tdata[31:0]), .tstep(s_tdata[55:32]),
                .r_p(p_init), .q_heading(regs[4]), .q_bias(regs[5]), .r_meas(regs[6]),
                .st, .o_kind(m_tuser), .o_frate(fr), .o_head(hd), .o_ok(ok));

  assign m_tdata = {7'd0, ok, hd, fr};
endmodule
